FILE: rtl/b64se_pkg.sv
// shared types, constants and character functions for the base64 stream encoder
package b64se_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SYM_W    = 6;
  localparam int unsigned MAX_CH   = 4;
  localparam int unsigned CIDX_W   = $clog2(MAX_CH);
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] NL_CHAR  = 8'h0A;
  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0]        CPL_RESET = 8'd72;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // one accepted request, expanded into the characters it produces
  typedef struct packed {
    logic [MAX_CH-1:0][CHAR_W-1:0] chars;
    logic [CIDX_W-1:0]             cnt_m1;
  } job_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic empty;
    job_t head;
  } q_stat_t;

  // base64 alphabet lookup
  function automatic logic [CHAR_W-1:0] sym_char(input logic [SYM_W-1:0] v);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (v < 6'd26)      c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62) c = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = 8'h2B;
    else                c = 8'h2F;
    return c;
  endfunction

endpackage

FILE: rtl/b64se_front.sv
// front end: takes requests, tracks group phase and line position, builds character jobs
module b64se_front import b64se_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] cpl,
  input  logic       push,
  input  logic       action,
  input  logic [7:0] data_byte,
  output job_t       job
);

  logic [1:0]       phase_r, phase_nxt;
  logic [SYM_W-1:0] left_r, left_nxt;
  logic [SYM_W-1:0] grp_r, grp_nxt;
  logic [SYM_W-1:0] quot;
  logic [SYM_W-1:0] grp_inc;

  assign quot    = cpl[7:2];
  assign grp_inc = grp_r + 6'd1;

  always_comb begin
    job       = '0;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    grp_nxt   = grp_r;
    if (action == ACT_END) begin
      case (phase_r)
        PH_ONE: begin
          job.chars[0] = sym_char(left_r);
          job.chars[1] = PAD_CHAR;
          job.chars[2] = PAD_CHAR;
          job.chars[3] = NL_CHAR;
          job.cnt_m1   = 2'd3;
        end
        PH_TWO: begin
          job.chars[0] = sym_char(left_r);
          job.chars[1] = PAD_CHAR;
          job.chars[2] = NL_CHAR;
          job.cnt_m1   = 2'd2;
        end
        default: begin
          job.chars[0] = NL_CHAR;
          job.cnt_m1   = 2'd0;
        end
      endcase
      phase_nxt = PH_START;
      left_nxt  = '0;
      grp_nxt   = '0;
    end else begin
      case (phase_r)
        PH_ONE: begin
          job.chars[0] = sym_char(left_r | {2'b00, data_byte[7:4]});
          job.cnt_m1   = 2'd0;
          left_nxt     = {data_byte[3:0], 2'b00};
          phase_nxt    = PH_TWO;
        end
        PH_TWO: begin
          job.chars[0] = sym_char(left_r | {4'b0000, data_byte[7:6]});
          job.chars[1] = sym_char(data_byte[5:0]);
          job.cnt_m1   = 2'd1;
          grp_nxt      = grp_inc;
          // line full after this group
          if (quot != '0 && grp_inc == quot) begin
            job.chars[2] = NL_CHAR;
            job.cnt_m1   = 2'd2;
            grp_nxt      = '0;
          end
          left_nxt  = '0;
          phase_nxt = PH_START;
        end
        default: begin
          job.chars[0] = sym_char(data_byte[7:2]);
          job.cnt_m1   = 2'd0;
          left_nxt     = {data_byte[1:0], 4'b0000};
          phase_nxt    = PH_ONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      left_r  <= '0;
      grp_r   <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      grp_r   <= grp_nxt;
    end
  end

endmodule

FILE: rtl/b64se_queue.sv
// small job queue between the front and back ends
module b64se_queue import b64se_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output logic    full,
  output q_stat_t stat
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/b64se_back.sv
// back end: walks the head job one character per cycle, unless the output stalls, into the output register
module b64se_back import b64se_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic [CIDX_W-1:0] idx_r;
  logic              valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  logic              load;
  logic              is_last;

  assign load    = (!valid_r || !out_stall) && !stat.empty;
  assign is_last = (idx_r == stat.head.cnt_m1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? '0 : idx_r + 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= stat.head.chars[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule

FILE: rtl/base64_stream_encoder_unit.sv
// top level of the streaming base64 encoder with line wrapping
// Streaming base64 encoder. Each request on the input channel is either a plaintext
// byte (in_action = 0) or an end-of-message marker (in_action = 1). A byte yields one
// or two alphabet characters, plus a newline when the line reaches cfg_data/4 groups
// (no wrapping when that quotient is zero); the end marker flushes the pending symbol
// with '=' padding and a newline, then returns to the start of a fresh message.
// out_last marks the final character caused by each request. The front end takes one
// request per clock while its two-entry job queue has room; the back end sends one
// character per clock unless the result channel stalls, and a request yields 1 to 4
// characters (3 at most for a byte), so the result channel sets the sustained rate.
// cfg_ready is always high; write the line length only while the encoder is idle.
module base64_stream_encoder_unit import b64se_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last,
  // line length register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] cpl_r;
  logic       q_full;
  logic       push;
  logic       pop;
  job_t       job;
  q_stat_t    q_stat;

  // line length register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpl_r <= CPL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cpl_r <= cfg_data;
    end
  end

  // accept a request whenever the queue has a free slot
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  b64se_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cpl       (cpl_r),
    .push      (push),
    .action    (in_action),
    .data_byte (in_data_byte),
    .job       (job)
  );

  // decouples request intake from character output
  b64se_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (q_full),
    .stat     (q_stat)
  );

  // one character per clock, unless the output stalls, into a registered output stage
  b64se_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the base64 stream encoder with line wrapping
module tb_top;
  import b64se_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any handshake before the run is declared hung
  localparam int STUCK_LIMIT = 2000;
  // receiver hold-off length and the request count that triggers it
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_REQ = 150;
  // mismatches reported in detail, the rest only counted
  localparam int REPORT_MAX  = 10;

  // one pending request for the encoder
  typedef struct packed {
    logic       act;
    logic [7:0] data;
  } enc_req_t;

  // one predicted output character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_action = ACT_DATA;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  // stimulus and scoreboard
  enc_req_t   pending_reqs[$];
  enc_char_t  expected_chars[$];
  int         fail_cnt = 0;
  int         req_accept_cnt = 0;
  int         stuck_cycles = 0;
  logic       req_taken = 1'b0;
  logic       hold_off = 1'b0;
  logic       quiet = 1'b0;

  // shadow state of the encoder
  logic [7:0] line_len = CPL_RESET;
  logic [1:0] enc_phase = PH_START;
  logic [5:0] enc_leftover = '0;
  logic [5:0] enc_groups = '0;

  string      enc_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_stream_encoder_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // alphabet lookup for one 6-bit symbol
  function automatic logic [7:0] symbol_char(input logic [5:0] v);
    return enc_alphabet[v];
  endfunction

  // expand one accepted request into the characters it must produce
  task automatic predict_request(input logic act, input logic [7:0] d);
    logic [7:0] chars[$];
    logic [5:0] quot;
    enc_char_t  item;
    quot = line_len[7:2];
    if (act == ACT_END) begin
      // flush the pending symbol with padding, then close the line
      if (enc_phase == PH_ONE) begin
        chars.push_back(symbol_char(enc_leftover));
        chars.push_back(PAD_CHAR);
        chars.push_back(PAD_CHAR);
      end else if (enc_phase == PH_TWO) begin
        chars.push_back(symbol_char(enc_leftover));
        chars.push_back(PAD_CHAR);
      end
      chars.push_back(NL_CHAR);
      enc_phase    = PH_START;
      enc_leftover = '0;
      enc_groups   = '0;
    end else if (enc_phase == PH_ONE) begin
      chars.push_back(symbol_char(enc_leftover | {2'b00, d[7:4]}));
      enc_leftover = {d[3:0], 2'b00};
      enc_phase    = PH_TWO;
    end else if (enc_phase == PH_TWO) begin
      chars.push_back(symbol_char(enc_leftover | {4'b0000, d[7:6]}));
      chars.push_back(symbol_char(d[5:0]));
      // group counter wraps modulo 64, newline only on an exact match
      enc_groups = enc_groups + 6'd1;
      if (quot != 6'd0 && enc_groups == quot) begin
        chars.push_back(NL_CHAR);
        enc_groups = '0;
      end
      enc_leftover = '0;
      enc_phase    = PH_START;
    end else begin
      chars.push_back(symbol_char(d[7:2]));
      enc_leftover = {d[1:0], 4'b0000};
      enc_phase    = PH_ONE;
    end
    foreach (chars[i]) begin
      item.ch   = chars[i];
      item.last = (i == chars.size() - 1);
      expected_chars.push_back(item);
    end
  endtask

  // request driver: inputs change on the falling edge
  always @(negedge clk) begin : drive_req
    enc_req_t nxt;
    if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && !(!quiet && $urandom_range(99) < 6)) begin
        nxt = pending_reqs.pop_front();
        in_valid     <= 1'b1;
        in_action    <= nxt.act;
        in_data_byte <= nxt.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus the long hold-off
  always @(negedge clk) begin
    out_stall <= hold_off || (!quiet && $urandom_range(99) < 6);
  end

  // predictor and checker, sampled on the rising edge
  always @(posedge clk) begin : check_out
    enc_char_t want;
    if (rst_n) begin
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        predict_request(in_action, in_data_byte);
        req_accept_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("unexpected char %h last %b with nothing pending", out_char, out_last);
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch || out_last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       want.ch, want.last, out_char, out_last);
          end
        end
      end
    end else begin
      req_taken = 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // receiver hold-off, counted in its own process so the job queue fills up
  initial begin
    wait (req_accept_cnt >= HOLD_AT_REQ);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic add_req(input logic act, input logic [7:0] d);
    enc_req_t r;
    r.act  = act;
    r.data = d;
    pending_reqs.push_back(r);
  endtask

  task automatic add_bytes(input int n);
    repeat (n) add_req(ACT_DATA, 8'($urandom));
  endtask

  // mostly whole messages with random content, some loose requests as noise
  task automatic add_traffic(input int n_items);
    int added;
    int len;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(0, 9);
        add_bytes(len);
        add_req(ACT_END, 8'($urandom));
        added += len + 1;
      end else begin
        add_req(1'($urandom), 8'($urandom));
        added++;
      end
    end
  endtask

  // everything sent and every character back, followed by idle slack
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // line length write, only issued while the encoder is idle
  task automatic write_line_len(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    line_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset line length
    add_req(ACT_END, 8'h00);                       // end with an empty group
    add_req(ACT_DATA, 8'h00);                      // end after one byte
    add_req(ACT_END, 8'h00);
    add_req(ACT_DATA, 8'hFF);                      // end after two bytes
    add_req(ACT_DATA, 8'hFF);
    add_req(ACT_END, 8'hFF);
    add_req(ACT_DATA, 8'hFF);                      // full group of ones
    add_req(ACT_DATA, 8'hFF);
    add_req(ACT_DATA, 8'hFF);
    add_req(ACT_DATA, 8'h00);                      // full group of zeros
    add_req(ACT_DATA, 8'h00);
    add_req(ACT_DATA, 8'h00);
    add_req(ACT_DATA, 8'h4D);                      // classic three-letter group
    add_req(ACT_DATA, 8'h61);
    add_req(ACT_DATA, 8'h6E);
    add_req(ACT_DATA, 8'h80);
    add_req(ACT_DATA, 8'h01);
    add_req(ACT_DATA, 8'hFE);
    add_req(ACT_END, 8'hA5);                       // data byte ignored on end
    add_req(ACT_END, 8'hFF);
    add_req(ACT_DATA, 8'h0F);
    add_req(ACT_DATA, 8'hF0);
    add_req(ACT_END, 8'h5A);
    wait_drained();

    // one group per line
    write_line_len(8'd4);
    add_traffic(60);
    wait_drained();

    // longest line, then lowered mid-line below the current count
    write_line_len(8'd255);
    add_bytes(150);
    wait_drained();
    write_line_len(8'd8);
    add_bytes(60);
    add_req(ACT_END, 8'($urandom));
    wait_drained();

    // no wrapping, and a stretch without any idling
    quiet = 1'b1;
    write_line_len(8'd0);
    add_bytes(30);
    add_traffic(30);
    wait_drained();
    quiet = 1'b0;

    // quotient zero from a nonzero length
    write_line_len(8'd3);
    add_traffic(30);
    wait_drained();

    // random line lengths
    repeat (2) begin
      write_line_len(8'($urandom_range(0, 255)));
      add_traffic(30);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && expected_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
